// ===== design/tamf_pkg.sv =====
package tamf_pkg;

   localparam int RAW_W                    = 16;
   localparam int SAMPLE_W                 = 12;
   localparam int SAMPLE_LSB               = RAW_W - SAMPLE_W;
   localparam int DEFAULT_SAMPLES_PER_AXIS = 12;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_MEDIAN
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic insert;   // insert the accepted sample into the sorted store
      logic load_x;   // capture the window median as the held X value
      logic load_y;   // capture held X and the window median into the result word
   } cmd_type;

endpackage

// ===== design/tamf_req_if.sv =====
interface tamf_req_if;
   import tamf_pkg::*;

   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink   (input valid, input raw_word, output ready);
endinterface

// ===== design/tamf_rsp_if.sv =====
interface tamf_rsp_if;
   import tamf_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] x_value;
   logic [SAMPLE_W-1:0] y_value;

   modport source (output valid, output x_value, output y_value, input ready);
   modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

// ===== design/tamf_ctrl.sv =====
module tamf_ctrl #(
   parameter int SAMPLES_PER_AXIS = tamf_pkg::DEFAULT_SAMPLES_PER_AXIS,
   parameter int IDX_W            = $clog2(SAMPLES_PER_AXIS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tamf_pkg::cmd_type cmd,
   output logic [IDX_W-1:0] fill_idx
);
   import tamf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_AXIS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic             axis_y_ff, axis_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   assign accept    = (state_ff == ST_COLLECT) && req_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fill_idx  = fill_ff;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && (fill_ff == LAST_IDX)) begin
               state_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            if (!axis_y_ff || out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      fill_in      = fill_ff;
      axis_y_in    = axis_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_COLLECT: begin
            req_ready  = 1'b1;
            cmd.insert = accept;
            if (accept) begin
               fill_in = (fill_ff == LAST_IDX) ? '0 : fill_ff + 1'b1;
            end
         end
         ST_MEDIAN: begin
            if (!axis_y_ff) begin
               cmd.load_x = 1'b1;
               axis_y_in  = 1'b1;
            end else if (out_free) begin
               cmd.load_y   = 1'b1;
               axis_y_in    = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         axis_y_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         axis_y_ff    <= axis_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/tamf_datapath.sv =====
module tamf_datapath #(
   parameter int SAMPLES_PER_AXIS = tamf_pkg::DEFAULT_SAMPLES_PER_AXIS,
   parameter int IDX_W            = $clog2(SAMPLES_PER_AXIS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tamf_pkg::cmd_type             cmd,
   input  logic [IDX_W-1:0]              fill_idx,
   input  logic [tamf_pkg::RAW_W-1:0]    raw_word,
   output logic [tamf_pkg::SAMPLE_W-1:0] x_value,
   output logic [tamf_pkg::SAMPLE_W-1:0] y_value
);
   import tamf_pkg::*;

   localparam int MID    = SAMPLES_PER_AXIS / 2;
   localparam int LO_POS = (MID > SAMPLES_PER_AXIS - 1) ? SAMPLES_PER_AXIS - 1 : MID;
   localparam int HI_POS = (MID + 1 > SAMPLES_PER_AXIS - 1) ? SAMPLES_PER_AXIS - 1 : MID + 1;

   logic [SAMPLE_W-1:0] store_ff [SAMPLES_PER_AXIS];
   logic [SAMPLE_W-1:0] store_in [SAMPLES_PER_AXIS];
   logic [SAMPLE_W-1:0] key;
   logic [SAMPLE_W:0]   pair_sum;
   logic [SAMPLE_W-1:0] median;
   logic [SAMPLE_W-1:0] held_x_ff;
   logic [SAMPLE_W-1:0] x_out_ff;
   logic [SAMPLE_W-1:0] y_out_ff;

   assign key = raw_word[RAW_W-1:SAMPLE_LSB];

   // each cell keeps, shifts up from its lower neighbor, or takes the key
   for (genvar g = 0; g < SAMPLES_PER_AXIS; g++) begin : g_cell
      logic prev_le;
      logic [SAMPLE_W-1:0] from_below;
      if (g == 0) begin : g_first
         assign prev_le    = 1'b1;
         assign from_below = key;
      end else begin : g_rest
         assign prev_le    = (store_ff[g-1] <= key);
         assign from_below = store_ff[g-1];
      end
      always_comb begin
         if (IDX_W'(g) < fill_idx) begin
            store_in[g] = (store_ff[g] > key) ? (prev_le ? key : from_below) : store_ff[g];
         end else if (IDX_W'(g) == fill_idx) begin
            store_in[g] = prev_le ? key : from_below;
         end else begin
            store_in[g] = store_ff[g];
         end
      end
   end

   assign pair_sum = {1'b0, store_ff[LO_POS]} + {1'b0, store_ff[HI_POS]};
   assign median   = pair_sum[SAMPLE_W:1];

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
      end else if (cmd.load_x) begin
         held_x_ff <= median;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_y) begin
         x_out_ff <= held_x_ff;
         y_out_ff <= median;
      end
   end

   assign x_value = x_out_ff;
   assign y_value = y_out_ff;

endmodule

// ===== design/touch_adc_median_filter.sv =====
// Median filter for touch converter samples.
//
// req_chan carries raw 16-bit converter words; bits 15..4 form the sample.
// Words are taken in windows of SAMPLES_PER_AXIS: first an X window, then
// a Y window. Each word is inserted into a sorted row of cells in the cycle
// it is accepted, so within a window one word is taken every cycle.
// After the last word of a window the block, in its median state with ready
// low, averages sorted cells SAMPLES_PER_AXIS/2 and the one above it,
// rounding down. After an X window the value is held; after a Y window
// held X and the new median are registered as one word with both
// coordinates on rsp_chan.
// The result word sits in an output register; the next windows are
// collected while it waits. Only if a new Y result is ready while the old
// one is still not taken does the median cycle stretch until rsp_chan frees.
// Reset (synchronous) returns to an empty X window with held X cleared and
// no result pending.
module touch_adc_median_filter #(
   parameter int SAMPLES_PER_AXIS = tamf_pkg::DEFAULT_SAMPLES_PER_AXIS
) (
   input logic       clock,
   input logic       reset,
   tamf_req_if.sink  req_chan,
   tamf_rsp_if.source rsp_chan
);
   import tamf_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES_PER_AXIS);

   cmd_type          cmd;
   logic [IDX_W-1:0] fill_idx;

   // controller: window count, axis, handshakes
   tamf_ctrl #(
      .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
      .IDX_W            (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .fill_idx  (fill_idx)
   );

   // datapath: sorted cells, median adder, held X and result word
   tamf_datapath #(
      .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
      .IDX_W            (IDX_W)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .fill_idx (fill_idx),
      .raw_word (req_chan.raw_word),
      .x_value  (rsp_chan.x_value),
      .y_value  (rsp_chan.y_value)
   );

endmodule

// ===== design/tamf_checker.sv =====
module tamf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tamf_pkg::SAMPLE_W-1:0] x_value,
   input logic [tamf_pkg::SAMPLE_W-1:0] y_value
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_value) && $stable(y_value))
      else $error("result word changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result follows the median cycle, in which no word is taken
   a_rise_after_median: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a median cycle");

   // input is refused only in the median state; a refusal while no result is
   // stalled is always followed by ready
   a_ready_gap: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !(rsp_valid && !rsp_ready) |=> req_ready)
      else $error("input stalled without cause");

endmodule

bind touch_adc_median_filter tamf_checker u_tamf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .x_value   (rsp_chan.x_value),
   .y_value   (rsp_chan.y_value)
);

// ===== bench/tb_touch_adc_median_filter.sv =====
module tb_touch_adc_median_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import tamf_pkg::*;

   localparam int          WINDOW       = DEFAULT_SAMPLES_PER_AXIS;
   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 12;
   // Settling margin after the last expected pair has arrived.
   localparam int          TAIL_CYCLES  = 16;
   // Watchdog limit, well above the slowest legal run.
   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int          PHASE_WORDS  = 416;

   // Shapes of a random window: touch-like clusters dominate, the rest
   // stresses the sorter with wide spreads, ties, ramps and rail values.
   typedef enum int {
      KIND_CLUSTER,
      KIND_SPREAD,
      KIND_FLAT,
      KIND_RAMP_UP,
      KIND_RAMP_DOWN,
      KIND_RAILS
   } window_kind_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x_value;
      logic [SAMPLE_W-1:0] y_value;
   } coord_pair_type;

   logic clock = 1'b0;
   logic reset;

   tamf_req_if req_if ();
   tamf_rsp_if rsp_if ();

   touch_adc_median_filter #(
      .SAMPLES_PER_AXIS(WINDOW)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle percentages of the current phase.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   // Mirror of the filter: sorted window, fill level, axis and held X.
   logic [SAMPLE_W-1:0] window_sorted [WINDOW];
   int unsigned         fill_level = 0;
   bit                  on_y_axis  = 1'b0;
   logic [SAMPLE_W-1:0] held_x_med = '0;

   coord_pair_type expected_coords [$];

   // Random window shape, chosen at the start of every window.
   window_kind_type     win_kind   = KIND_CLUSTER;
   int                  win_center = 0;
   int                  win_step   = 0;

   // Insert one accepted word into the mirror; queue a coordinate pair
   // when a Y window closes.
   task automatic predict_word(input logic [RAW_W-1:0] word);
      logic [SAMPLE_W-1:0] key;
      logic [SAMPLE_W:0]   sum;
      logic [SAMPLE_W-1:0] med;
      int                  pos;
      int                  lo;
      int                  hi;
      coord_pair_type      pair;
      key = word[RAW_W-1:SAMPLE_LSB];
      pos = (fill_level > WINDOW - 1) ? WINDOW - 1 : fill_level;
      // shift larger entries up; ties keep the new key after equal ones
      while (pos > 0 && window_sorted[pos-1] > key) begin
         window_sorted[pos] = window_sorted[pos-1];
         pos--;
      end
      window_sorted[pos] = key;
      fill_level++;
      if (fill_level == WINDOW) begin
         lo = WINDOW / 2;
         hi = lo + 1;
         if (lo > WINDOW - 1) lo = WINDOW - 1;
         if (hi > WINDOW - 1) hi = WINDOW - 1;
         sum = {1'b0, window_sorted[lo]} + {1'b0, window_sorted[hi]};
         med = sum[SAMPLE_W:1];
         fill_level = 0;
         if (!on_y_axis) begin
            held_x_med = med;
            on_y_axis  = 1'b1;
         end else begin
            on_y_axis    = 1'b0;
            pair.x_value = held_x_med;
            pair.y_value = med;
            expected_coords.push_back(pair);
         end
      end
   endtask

   // Offer one word, idling first at the phase's rate; return once taken.
   // Valid stays high after acceptance so back-to-back words need no toggle.
   task automatic send_word(input logic [RAW_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.raw_word <= word;
      do @(posedge clock); while (!req_if.ready);
      predict_word(word);
   endtask

   // Drop valid, hold until every pair has arrived, then let the pipe settle.
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) return '0;
      if (v > (1 << SAMPLE_W) - 1) return '1;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic pick_window_kind();
      int unsigned roll;
      roll       = $urandom_range(99);
      win_center = $urandom_range((1 << SAMPLE_W) - 1);
      win_step   = $urandom_range(300);
      if (roll < 45)      win_kind = KIND_CLUSTER;
      else if (roll < 65) win_kind = KIND_SPREAD;
      else if (roll < 75) win_kind = KIND_FLAT;
      else if (roll < 83) win_kind = KIND_RAMP_UP;
      else if (roll < 91) win_kind = KIND_RAMP_DOWN;
      else                win_kind = KIND_RAILS;
   endtask

   // Build the next raw word for the current window shape; the low nibble
   // is always random since the block must ignore it.
   function automatic logic [RAW_W-1:0] make_raw_word();
      logic [SAMPLE_W-1:0]         sample;
      logic [SAMPLE_LSB-1:0]       nibble;
      logic [RAW_W-1:0]            full;
      nibble = SAMPLE_LSB'($urandom);
      full   = RAW_W'($urandom);
      case (win_kind)
         KIND_CLUSTER:   sample = clamp_sample(win_center + $urandom_range(40) - 20);
         KIND_SPREAD:    return full;
         KIND_FLAT:      sample = clamp_sample(win_center);
         KIND_RAMP_UP:   sample = clamp_sample(win_center + fill_level * win_step);
         KIND_RAMP_DOWN: sample = clamp_sample(win_center - fill_level * win_step);
         default: begin
            case ($urandom_range(3))
               0:       sample = '0;
               1:       sample = '1;
               2:       sample = SAMPLE_W'(1);
               default: sample = SAMPLE_W'((1 << SAMPLE_W) - 2);
            endcase
         end
      endcase
      return {sample, nibble};
   endfunction

   task automatic run_words(input int unsigned n_words);
      for (int unsigned i = 0; i < n_words; i++) begin
         if (fill_level == 0) pick_window_kind();
         send_word(make_raw_word());
      end
   endtask

   // Rails, ignored low bits, ties and a reversed run in the X window;
   // an all-max Y window so the middle sum reaches its 13-bit top.
   task automatic test_directed_extremes();
      logic [RAW_W-1:0] x_words [WINDOW] = '{
         16'h0000, 16'hFFFF, 16'h000F, 16'hFFF0, 16'h8000, 16'h7FFF,
         16'h0010, 16'hFFEF, 16'h5555, 16'h5550, 16'h5559, 16'hAAAA
      };
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (x_words[i]) send_word(x_words[i]);
      for (int i = 0; i < WINDOW; i++) send_word(16'hFFF0 | 16'(4'(i)));
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_words(PHASE_WORDS);
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 81;
      recv_stall_pct = 0;
      run_words(PHASE_WORDS);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 81;
      run_words(PHASE_WORDS);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      run_words(PHASE_WORDS);
   endtask

   // Stop mid-stream until the output side is empty, then resume; the
   // partial window in the mirror must carry over the pause.
   task automatic test_drain_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 50;
      run_words(5 * WINDOW / 2);
      wait_for_results();
      recv_stall_pct = 0;
      run_words(5 * WINDOW / 2);
   endtask

   // Receiver: stall at the phase's rate, registered at the clock edge.
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else       rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare every taken pair with the oldest expectation.
   always @(posedge clock) begin
      coord_pair_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_coords.size() == 0) begin
            $error("unexpected result: x_value %0d y_value %0d",
                   rsp_if.x_value, rsp_if.y_value);
            fail_count++;
         end else begin
            want = expected_coords.pop_front();
            if (rsp_if.x_value !== want.x_value) begin
               $error("x_value: expected %0d, actual %0d", want.x_value, rsp_if.x_value);
               fail_count++;
            end
            if (rsp_if.y_value !== want.y_value) begin
               $error("y_value: expected %0d, actual %0d", want.y_value, rsp_if.y_value);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // drive every input before the first edge; the receiver drives its ready
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.raw_word <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_back_to_back();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_drain_pause();
      wait_for_results();

      if (fail_count == 0 && expected_coords.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
